// ----- rtl/core/sct_pkg.sv -----
package sct_pkg;

    localparam int BUFFER_DEPTH  = 512;
    localparam int HYSTERESIS_MV = 100;

    localparam int SLOT_W   = $clog2(BUFFER_DEPTH);
    localparam int FILL_W   = SLOT_W + 1;
    localparam int CNT_W    = 25;
    localparam int SAMPLE_W = 16;
    localparam int DEC_W    = 24;
    localparam int LEVEL_W  = 15;
    localparam int HOLD_W   = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CMP_W    = SAMPLE_W + 1;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUFFER_DEPTH);

    typedef enum logic [1:0] {
        CAUSE_FREE_RUN = 2'd0,
        CAUSE_TRIGGER  = 2'd1,
        CAUSE_HOLDOFF  = 2'd2
    } rearm_cause_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECIMATION = 3'd0,
        REG_LEVEL      = 3'd1,
        REG_HOLDOFF    = 3'd2,
        REG_XY_MODE    = 3'd3,
        REG_EXT_SOURCE = 3'd4,
        REG_TRIG_CONN  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [DEC_W-1:0]          decimation_count;
        logic signed [LEVEL_W-1:0] trigger_level;
        logic [HOLD_W-1:0]         holdoff_samples;
        logic                      xy_mode;
        logic                      external_source;
        logic                      trigger_connected;
    } cfg_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill_index;
        logic [CNT_W-1:0]  tick_counter;
        logic              schmitt_high;
    } state_t;

    typedef struct packed {
        logic                       write_valid;
        logic [SLOT_W-1:0]          write_slot;
        logic signed [SAMPLE_W-1:0] stored_x;
        logic signed [SAMPLE_W-1:0] stored_y;
        logic                       rearmed;
        rearm_cause_t               rearm_cause;
    } result_t;

endpackage

// ----- rtl/core/scope_capture_trigger.sv -----
// Scope capture and trigger: one result item per sample item, in order. A sample is
// registered on entry and its result is then registered again at the output; one sample
// is taken every cycle while m_ready is high; the rate is set by the single tick
// update of the fill index, tick counter and Schmitt flag.
// After a full buffer of BUFFER_DEPTH writes the block rearms at once (XY mode, or
// external source with nothing connected) or waits for a rising trigger edge or the
// hold-off. Write configuration registers only while no item is in flight.
module scope_capture_trigger (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [sct_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sct_pkg::CFG_W-1:0]           cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sct_pkg::SAMPLE_W-1:0] s_x_sample,
    input  logic signed [sct_pkg::SAMPLE_W-1:0] s_y_sample,
    input  logic signed [sct_pkg::SAMPLE_W-1:0] s_trig_sample,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_write_valid,
    output logic [sct_pkg::SLOT_W-1:0]          m_write_slot,
    output logic signed [sct_pkg::SAMPLE_W-1:0] m_stored_x,
    output logic signed [sct_pkg::SAMPLE_W-1:0] m_stored_y,
    output logic                                m_rearmed,
    output logic [1:0]                          m_rearm_cause
);
    import sct_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;

    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [SAMPLE_W-1:0] trig_reg;
    logic                       out_valid_reg;
    logic                       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.decimation_count  <= DEC_W'(3);
            cfg_reg.trigger_level     <= '0;
            cfg_reg.holdoff_samples   <= HOLD_W'(4410);
            cfg_reg.xy_mode           <= 1'b0;
            cfg_reg.external_source   <= 1'b0;
            cfg_reg.trigger_connected <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_DECIMATION: cfg_reg.decimation_count  <= cfg_wr_data[DEC_W-1:0];
                REG_LEVEL:      cfg_reg.trigger_level     <= cfg_wr_data[LEVEL_W-1:0];
                REG_HOLDOFF:    cfg_reg.holdoff_samples   <= cfg_wr_data[HOLD_W-1:0];
                REG_XY_MODE:    cfg_reg.xy_mode           <= cfg_wr_data[0];
                REG_EXT_SOURCE: cfg_reg.external_source   <= cfg_wr_data[0];
                REG_TRIG_CONN:  cfg_reg.trigger_connected <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    sct_tick u_tick (
        .cfg         (cfg_reg),
        .state       (state_reg),
        .x_sample    (x_reg),
        .y_sample    (y_reg),
        .trig_sample (trig_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.fill_index   <= '0;
            state_reg.tick_counter <= '0;
            state_reg.schmitt_high <= 1'b1;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg    <= s_x_sample;
            y_reg    <= s_y_sample;
            trig_reg <= s_trig_sample;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_write_valid = result_reg.write_valid;
    assign m_write_slot  = result_reg.write_slot;
    assign m_stored_x    = result_reg.stored_x;
    assign m_stored_y    = result_reg.stored_y;
    assign m_rearmed     = result_reg.rearmed;
    assign m_rearm_cause = result_reg.rearm_cause;

endmodule

// ----- rtl/core/sct_tick.sv -----
module sct_tick (
    input  sct_pkg::cfg_t                         cfg,
    input  sct_pkg::state_t                       state,
    input  logic signed [sct_pkg::SAMPLE_W-1:0]   x_sample,
    input  logic signed [sct_pkg::SAMPLE_W-1:0]   y_sample,
    input  logic signed [sct_pkg::SAMPLE_W-1:0]   trig_sample,
    output sct_pkg::state_t                       state_next,
    output sct_pkg::result_t                      result
);
    import sct_pkg::*;

    logic [FILL_W-1:0]        fill;
    logic [CNT_W-1:0]         cnt;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     high;
    logic                     fired;
    logic signed [CMP_W-1:0]  gate;
    logic signed [CMP_W-1:0]  level;
    logic signed [CMP_W-1:0]  low_level;

    assign level     = CMP_W'(cfg.trigger_level);
    assign low_level = level - CMP_W'(HYSTERESIS_MV);
    assign gate      = cfg.external_source ? CMP_W'(trig_sample) : CMP_W'(x_sample);

    always_comb begin
        fill    = state.fill_index;
        cnt     = state.tick_counter;
        high    = state.schmitt_high;
        fired   = 1'b0;
        cnt_inc = '0;
        result  = '0;

        // capture phase
        if (fill < FILL_FULL) begin
            cnt = cnt + CNT_W'(1);
            if (cnt > CNT_W'(cfg.decimation_count)) begin
                cnt                = '0;
                result.write_valid = 1'b1;
                result.write_slot  = fill[SLOT_W-1:0];
                result.stored_x    = x_sample;
                result.stored_y    = y_sample;
                fill               = fill + FILL_W'(1);
            end
        end

        // rearm phase
        if (fill >= FILL_FULL) begin
            if (cfg.xy_mode || (cfg.external_source && !cfg.trigger_connected)) begin
                fill               = '0;
                cnt                = '0;
                result.rearmed     = 1'b1;
                result.rearm_cause = CAUSE_FREE_RUN;
            end else begin
                if (cnt == '0) begin
                    high = 1'b1;
                end
                cnt_inc = cnt + CNT_W'(1);
                cnt     = cnt_inc;
                if (high) begin
                    if (gate <= low_level) begin
                        high = 1'b0;
                    end
                end else if (gate >= level) begin
                    high  = 1'b1;
                    fired = 1'b1;
                end
                if (fired || (cnt_inc >= CNT_W'(cfg.holdoff_samples))) begin
                    fill               = '0;
                    cnt                = '0;
                    result.rearmed     = 1'b1;
                    result.rearm_cause = fired ? CAUSE_TRIGGER : CAUSE_HOLDOFF;
                end
            end
        end

        state_next.fill_index   = fill;
        state_next.tick_counter = cnt;
        state_next.schmitt_high = high;
    end

endmodule
